@@ design/twrt_pkg.sv @@
// Package with widths, codes and register map of the tokened write retry tracker.
package twrt_pkg;

	localparam int TOKEN_W  = 32;
	localparam int TIME_W   = 32;
	localparam int SENSOR_W = 32;
	localparam int VALUE_W  = 12;
	localparam int SHOWQ_W  = 11;
	localparam int CFG_W    = 16;
	localparam int CODE_W   = 8;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 4;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(600);
	localparam logic [CFG_W-1:0] RESEND_RESET = CFG_W'(60);
	localparam logic [CFG_W-1:0] PROBE_RESET  = CFG_W'(60);

	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_RESEND = 2'd1,
		REG_PROBE  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_QUEUE   = 3'd1,
		ACT_CANCEL  = 3'd2,
		ACT_ATTEMPT = 3'd3,
		ACT_REPLY   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_NOTHING   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_REFUSED   = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_PROBE     = 3'd4,
		ST_WRITE     = 3'd5,
		ST_DISCARDED = 3'd6,
		ST_RESOLVED  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		VD_NONE          = 3'd0,
		VD_APPLIED       = 3'd1,
		VD_REJECTED      = 3'd2,
		VD_FAILED        = 3'd3,
		VD_NOT_SUPPORTED = 3'd4
	} verdict_t;

endpackage

@@ design/twrt_evt_if.sv @@
// Event channel interface: valid, ready and the fields of one event item.
interface twrt_evt_if;
	import twrt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [2:0]                 action;
	logic [TIME_W-1:0]          now;
	logic [SENSOR_W-1:0]        dev_id;
	logic signed [VALUE_W-1:0]  value;
	logic                       link_known;
	logic                       perm_known;
	logic                       permitted;
	logic                       write_accepted;
	logic [CODE_W-1:0]          reply_code;
	logic [TOKEN_W-1:0]         reply_token;

	modport source (
		output valid, action, now, dev_id, value, link_known, perm_known,
			permitted, write_accepted, reply_code, reply_token,
		input  ready
	);

	modport sink (
		input  valid, action, now, dev_id, value, link_known, perm_known,
			permitted, write_accepted, reply_code, reply_token,
		output ready
	);

endinterface

@@ design/twrt_res_if.sv @@
// Result channel interface: valid, ready and the fields of one result item.
interface twrt_res_if;
	import twrt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [2:0]                 event_status;
	logic signed [VALUE_W-1:0]  out_value;
	logic [SENSOR_W-1:0]        out_sensor;
	logic [TOKEN_W-1:0]         out_token;
	logic [2:0]                 verdict;
	logic [SHOWQ_W-1:0]         shown_queued;
	logic signed [VALUE_W-1:0]  shown_last_value;
	logic [2:0]                 shown_last_verdict;
	logic [TIME_W-1:0]          shown_last_time;

	modport source (
		output valid, event_status, out_value, out_sensor, out_token, verdict,
			shown_queued, shown_last_value, shown_last_verdict, shown_last_time,
		input  ready
	);

	modport sink (
		input  valid, event_status, out_value, out_sensor, out_token, verdict,
			shown_queued, shown_last_value, shown_last_verdict, shown_last_time,
		output ready
	);

endinterface

@@ design/tokened_write_retry_tracker_unit.sv @@
// Top level of the tokened write retry tracker: entry state, event decode and result register.
//
//  channel  direction  handshake          content
//  evt      in         valid/ready        one event item per accept
//  res      out        valid/ready        one result item per event
//  apb      in         psel/penable       window, resend and probe registers
//
// Each event item is decoded and applied to the entry state in the cycle it is
// accepted, and its result item is valid in the result register on the next cycle.
// One item is taken per cycle; a new item is accepted while the result register
// is empty or its item is taken in the same cycle. A stalled result holds evt
// off. Reset clears the entry, the token counter and the last record.
module tokened_write_retry_tracker_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	twrt_evt_if.sink                     evt,
	twrt_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [twrt_pkg::PADDR_W-1:0] paddr,
	input  logic [twrt_pkg::PDATA_W-1:0] pwdata,
	output logic [twrt_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import twrt_pkg::*;

	logic [CFG_W-1:0] window_q, resend_q, probe_q;

	logic signed [VALUE_W-1:0] queued_value_q, last_value_q;
	logic [SENSOR_W-1:0]       queued_sensor_q, last_sensor_q;
	logic [TOKEN_W-1:0]        live_token_q, next_token_q;
	logic [TIME_W-1:0]         giveup_time_q, resend_time_q, probe_time_q, last_time_q;
	logic [2:0]                last_verdict_q;

	logic signed [VALUE_W-1:0] queued_value_d, last_value_d;
	logic [SENSOR_W-1:0]       queued_sensor_d, last_sensor_d;
	logic [TOKEN_W-1:0]        live_token_d, next_token_d, tok_inc;
	logic [TIME_W-1:0]         giveup_time_d, resend_time_d, probe_time_d, last_time_d;
	logic [2:0]                last_verdict_d;

	logic [2:0]                status_d, verdict_d;
	logic signed [VALUE_W-1:0] ov_d;
	logic [SENSOR_W-1:0]       os_d;
	logic [TOKEN_W-1:0]        ot_d;
	logic [SHOWQ_W-1:0]        sq_d;
	logic                      shown_d;

	logic                      res_valid_q;
	logic                      evt_fire;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;
	logic                      have_entry;

	assign pready   = 1'b1;
	assign cfg_idx  = reg_idx_t'(paddr[3:2]);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign evt.ready = !res_valid_q || res.ready;
	assign evt_fire = evt.valid && evt.ready;
	assign have_entry = queued_value_q > 0;
	assign tok_inc  = next_token_q + TOKEN_W'(1);

	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW: prdata = PDATA_W'(window_q);
			REG_RESEND: prdata = PDATA_W'(resend_q);
			REG_PROBE:  prdata = PDATA_W'(probe_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			resend_q <= RESEND_RESET;
			probe_q  <= PROBE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WINDOW: window_q <= pwdata[CFG_W-1:0];
				REG_RESEND: resend_q <= pwdata[CFG_W-1:0];
				REG_PROBE:  probe_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		queued_value_d  = queued_value_q;
		queued_sensor_d = queued_sensor_q;
		live_token_d    = live_token_q;
		next_token_d    = next_token_q;
		giveup_time_d   = giveup_time_q;
		resend_time_d   = resend_time_q;
		probe_time_d    = probe_time_q;
		last_value_d    = last_value_q;
		last_verdict_d  = last_verdict_q;
		last_sensor_d   = last_sensor_q;
		last_time_d     = last_time_q;
		status_d        = ST_NOTHING;
		verdict_d       = VD_NONE;
		ov_d            = '0;
		os_d            = '0;
		ot_d            = '0;

		case (evt.action)
			ACT_TICK: begin
				if (have_entry && giveup_time_q != '0 && evt.now > giveup_time_q) begin
					verdict_d = VD_FAILED;
					status_d  = ST_RESOLVED;
				end
			end
			ACT_QUEUE: begin
				if (evt.value <= 0) begin
					status_d = ST_REFUSED;
				end else begin
					queued_value_d  = evt.value;
					queued_sensor_d = evt.dev_id;
					next_token_d    = (tok_inc == '0) ? TOKEN_W'(1) : tok_inc;
					live_token_d    = next_token_d;
					giveup_time_d   = evt.now + TIME_W'(window_q);
					resend_time_d   = '0;
					probe_time_d    = '0;
					status_d        = ST_QUEUED;
				end
			end
			ACT_CANCEL: begin
				status_d = ST_CANCELLED;
			end
			ACT_ATTEMPT: begin
				if (have_entry && queued_sensor_q == evt.dev_id && evt.link_known) begin
					if (evt.perm_known && !evt.permitted) begin
						verdict_d = VD_NOT_SUPPORTED;
						status_d  = ST_RESOLVED;
					end else if (!evt.perm_known) begin
						if (evt.now >= probe_time_q) begin
							probe_time_d = evt.now + TIME_W'(probe_q);
							status_d     = ST_PROBE;
						end
					end else if (evt.now >= resend_time_q && evt.write_accepted) begin
						ov_d          = queued_value_q;
						os_d          = queued_sensor_q;
						ot_d          = live_token_q;
						resend_time_d = evt.now + TIME_W'(resend_q);
						status_d      = ST_WRITE;
					end
				end
			end
			ACT_REPLY: begin
				if (!have_entry || queued_sensor_q != evt.dev_id ||
						queued_value_q != evt.value || live_token_q != evt.reply_token) begin
					status_d = ST_DISCARDED;
				end else begin
					verdict_d = (evt.reply_code == '0) ? VD_APPLIED : VD_REJECTED;
					status_d  = ST_RESOLVED;
				end
			end
			default: ;
		endcase

		if (status_d == ST_RESOLVED) begin
			ov_d           = queued_value_q;
			os_d           = queued_sensor_q;
			last_value_d   = queued_value_q;
			last_time_d    = evt.now;
			last_verdict_d = verdict_d;
			last_sensor_d  = queued_sensor_q;
		end

		if (status_d == ST_RESOLVED || status_d == ST_CANCELLED) begin
			queued_value_d  = '0;
			queued_sensor_d = '0;
			live_token_d    = '0;
			giveup_time_d   = '0;
			resend_time_d   = '0;
			probe_time_d    = '0;
		end

		sq_d = (queued_value_d > 0 && queued_sensor_d == evt.dev_id) ?
			queued_value_d[SHOWQ_W-1:0] : '0;
		shown_d = (sq_d == '0) && (last_time_d != '0) && (last_sensor_d == evt.dev_id);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_value_q  <= '0;
			queued_sensor_q <= '0;
			live_token_q    <= '0;
			next_token_q    <= '0;
			giveup_time_q   <= '0;
			resend_time_q   <= '0;
			probe_time_q    <= '0;
			last_value_q    <= '0;
			last_verdict_q  <= '0;
			last_sensor_q   <= '0;
			last_time_q     <= '0;
		end else if (evt_fire) begin
			queued_value_q  <= queued_value_d;
			queued_sensor_q <= queued_sensor_d;
			live_token_q    <= live_token_d;
			next_token_q    <= next_token_d;
			giveup_time_q   <= giveup_time_d;
			resend_time_q   <= resend_time_d;
			probe_time_q    <= probe_time_d;
			last_value_q    <= last_value_d;
			last_verdict_q  <= last_verdict_d;
			last_sensor_q   <= last_sensor_d;
			last_time_q     <= last_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (evt_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			res.event_status       <= status_d;
			res.out_value          <= ov_d;
			res.out_sensor         <= os_d;
			res.out_token          <= ot_d;
			res.verdict            <= verdict_d;
			res.shown_queued       <= sq_d;
			res.shown_last_value   <= shown_d ? last_value_d : '0;
			res.shown_last_verdict <= shown_d ? last_verdict_d : '0;
			res.shown_last_time    <= shown_d ? last_time_d : '0;
		end
	end

	assign res.valid = res_valid_q;

endmodule
